### design/tlap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlap_pkg
// Shared types, constants and helpers for the two-link arm position core.
// ----------------------------------------------------------------------------
package tlap_pkg;

  localparam int AngleBits   = 16;
  localparam int LengthBits  = 16;
  localparam int TrigBits    = 16;
  localparam int PosBits     = 18;
  localparam int DegBits     = 16;
  localparam int BiasOutBits = 16;
  localparam int CfgAddrBits = 4;
  localparam int CfgDataBits = 32;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrBits = 1;
  localparam int QueueCntBits = 2;

  // 360 degrees in 1/128 degree units
  localparam logic [31:0] Deg128PerTurn = 32'd46080;
  // pi in Q29
  localparam logic [31:0] PiQ29 = 32'd1686629713;
  localparam logic [31:0] OneQ30 = 32'd1 << 30;

  // ceil(2^k / d) with k = 31 + ceil(log2 d): exact floor division for values below 2^31
  localparam logic [31:0] RecipDiv72 = 32'(((64'd1 << 38) + 64'd71) / 64'd72);
  localparam logic [31:0] RecipDiv42 = 32'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [31:0] RecipDiv20 = 32'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [31:0] RecipDiv6  = 32'(((64'd1 << 34) + 64'd5) / 64'd6);
  localparam logic [31:0] RecipDiv90 = 32'(((64'd1 << 38) + 64'd89) / 64'd90);
  localparam logic [31:0] RecipDiv56 = 32'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam logic [31:0] RecipDiv30 = 32'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [31:0] RecipDiv12 = 32'(((64'd1 << 35) + 64'd11) / 64'd12);

  typedef enum logic [1:0] {
    CMD_POS   = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_EN    = 2'd1,
    ST_READ_FAIL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_ENABLED = 2'd0,
    REG_LEN1    = 2'd1,
    REG_LEN2    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TRIG,
    BK_POS,
    BK_EMIT
  } back_state_t;

  // one step of the shared multiplier per cycle while evaluating sine and cosine
  typedef enum logic [4:0] {
    TS_ANGLE, TS_SQUARE,
    TS_S1_MUL, TS_S1_DIV, TS_S2_MUL, TS_S2_DIV, TS_S3_MUL, TS_S3_DIV,
    TS_S4_MUL, TS_S4_DIV, TS_S_FINAL,
    TS_C1_MUL, TS_C1_DIV, TS_C2_MUL, TS_C2_DIV, TS_C3_MUL, TS_C3_DIV,
    TS_C4_MUL, TS_C4_DIV, TS_C5_MUL, TS_C_DONE,
    TS_QUANT
  } trig_step_t;

  typedef enum logic [2:0] {
    PS_X1, PS_X2, PS_Y1, PS_Y2, PS_Y_DONE
  } pos_step_t;

  typedef struct packed {
    status_t                status;
    logic                   compute;
    logic [AngleBits-1:0]   t1;
    logic [AngleBits-1:0]   t12;
    logic [DegBits-1:0]     deg;
    logic [BiasOutBits-1:0] bias1;
    logic [BiasOutBits-1:0] bias2;
  } job_t;

  // round half up to Q1.(TrigBits-1) and saturate
  function automatic logic [TrigBits-2:0] trig_round(input logic [30:0] mag);
    logic [31:0] rsum;
    logic [31:0] q;
    rsum = {1'b0, mag} + (32'd1 << (30 - TrigBits));
    q = rsum >> (31 - TrigBits);
    if (q > ((32'd1 << (TrigBits - 1)) - 32'd1)) begin
      trig_round = '1;
    end else begin
      trig_round = q[TrigBits-2:0];
    end
  endfunction

  function automatic logic signed [TrigBits-1:0] trig_sign(
    input logic [TrigBits-2:0] r, input logic neg);
    logic signed [TrigBits-1:0] v;
    v = $signed({1'b0, r});
    trig_sign = neg ? -v : v;
  endfunction

endpackage
`default_nettype wire

### design/tlap_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlap_queue
// Short job queue between the command front end and the compute back end.
// ----------------------------------------------------------------------------
module tlap_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tlap_pkg::job_t din,
  input  logic          pop,
  output tlap_pkg::job_t dout,
  output logic          full,
  output logic          avail
);
  import tlap_pkg::*;

  job_t                    mem [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr;
  logic [QueuePtrBits-1:0] rd_ptr;
  logic [QueueCntBits-1:0] count;

  assign full  = (count == QueueCntBits'(QueueDepth));
  assign avail = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/tlap_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlap_front
// Accepts commands, checks enable and encoder status, keeps the joint biases
// and hands a classified job to the queue.
// ----------------------------------------------------------------------------
module tlap_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           enabled,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     cmd,
  input  logic [tlap_pkg::AngleBits-1:0] angle_first,
  input  logic [tlap_pkg::AngleBits-1:0] angle_second,
  input  logic                           read_failed,
  input  logic                           q_full,
  output logic                           push,
  output tlap_pkg::job_t                 job
);
  import tlap_pkg::*;

  logic [AngleBits-1:0] bias_first;
  logic [AngleBits-1:0] bias_second;
  logic [AngleBits-1:0] bias_first_next;
  logic [AngleBits-1:0] bias_second_next;
  logic [AngleBits-1:0] t1;
  logic [AngleBits-1:0] t2;
  logic [31:0]          deg_prod;
  logic                 compute;
  status_t              st;
  logic [DegBits-1:0]   deg_val;
  cmd_t                 cmd_dec;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign cmd_dec  = cmd_t'(cmd);

  assign t1 = angle_first - bias_first;
  assign t2 = angle_second - bias_second;
  assign deg_prod = 32'(angle_second) * Deg128PerTurn + (32'd1 << (AngleBits - 1));

  always_comb begin
    bias_first_next  = bias_first;
    bias_second_next = bias_second;
    st               = ST_OK;
    compute          = 1'b0;
    deg_val          = '0;
    if (!enabled) begin
      st = ST_NOT_EN;
    end else if (read_failed && (cmd_dec == CMD_POS || cmd_dec == CMD_LOAD)) begin
      st = ST_READ_FAIL;
    end else begin
      unique case (cmd_dec)
        CMD_POS: begin
          compute = 1'b1;
        end
        CMD_LOAD: begin
          bias_first_next  = angle_first;
          bias_second_next = angle_second;
          deg_val          = deg_prod[AngleBits +: DegBits];
        end
        CMD_CLEAR: begin
          bias_first_next  = '0;
          bias_second_next = '0;
        end
        CMD_NOP: begin
          compute = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    job.status  = st;
    job.compute = compute;
    job.t1      = t1;
    job.t12     = t1 + t2;
    job.deg     = deg_val;
    job.bias1   = BiasOutBits'(bias_first_next);
    job.bias2   = BiasOutBits'(bias_second_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_first  <= '0;
      bias_second <= '0;
    end else if (push) begin
      bias_first  <= bias_first_next;
      bias_second <= bias_second_next;
    end
  end

endmodule
`default_nettype wire

### design/tlap_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlap_back
// Runs a job; for a position job, sine and cosine by series on one shared
// multiplier, then the two link projections. Output register holds result.
// ----------------------------------------------------------------------------
module tlap_back (
  input  logic                            clk,
  input  logic                            rst,
  input  tlap_pkg::job_t                  job,
  input  logic                            job_avail,
  output logic                            job_pop,
  input  logic [tlap_pkg::LengthBits-1:0] len_first,
  input  logic [tlap_pkg::LengthBits-1:0] len_second,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic signed [tlap_pkg::PosBits-1:0] pos_x,
  output logic signed [tlap_pkg::PosBits-1:0] pos_y,
  output logic [tlap_pkg::DegBits-1:0]    bias_degrees,
  output logic [tlap_pkg::BiasOutBits-1:0] bias_first_now,
  output logic [tlap_pkg::BiasOutBits-1:0] bias_second_now
);
  import tlap_pkg::*;

  localparam int ProdBits = LengthBits + 1 + TrigBits;
  localparam int SumBits  = ProdBits + 1;
  localparam int RndBits  = SumBits + 1;

  back_state_t state;
  back_state_t state_next;
  trig_step_t  ts;
  pos_step_t   ps;
  logic        phase;
  job_t        cur;
  logic        load_out;

  logic [63:0] p;
  logic [29:0] x;
  logic [29:0] x2;
  logic [30:0] s_mag;
  logic [30:0] c_mag;
  logic signed [TrigBits-1:0] sin1, cos1, sin12, cos12;
  logic signed [ProdBits-1:0] pm;
  logic signed [ProdBits-1:0] acc;
  logic signed [PosBits-1:0]  res_x, res_y;

  logic [AngleBits-1:0] ang;
  logic [2:0]           oct;
  logic [28:0]          f29;
  logic [29:0]          f_fold;
  logic [63:0]          rnd;
  logic [29:0]          x_now;
  logic [31:0]          hi;
  logic [31:0]          qk;
  logic [31:0]          v_now;
  logic [31:0]          mul_a, mul_b;
  logic [30:0]          c_now;
  logic [TrigBits-2:0]  qs, qc;
  logic                 swap, sn_neg, cs_neg;
  logic signed [TrigBits-1:0] sin_v, cos_v;
  logic signed [LengthBits:0] pl;
  logic signed [TrigBits-1:0] pt;
  logic signed [SumBits-1:0]  psum;
  logic signed [PosBits-1:0]  pround;

  function automatic logic signed [PosBits-1:0] len_round(
    input logic signed [SumBits-1:0] v);
    logic signed [RndBits-1:0] q;
    logic signed [RndBits-1:0] r;
    logic signed [RndBits-1:0] lim;
    lim = RndBits'((1 << (PosBits - 1)) - 1);
    q = RndBits'(v) + (RndBits'(1) <<< (TrigBits - 2));
    r = q >>> (TrigBits - 1);
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    len_round = r[PosBits-1:0];
  endfunction

  // angle folding into one octant
  assign ang    = phase ? cur.t12 : cur.t1;
  assign oct    = ang[AngleBits-1 -: 3];
  assign f29    = {ang[AngleBits-4:0], {(32 - AngleBits){1'b0}}};
  assign f_fold = oct[0] ? ((30'd1 << 29) - {1'b0, f29}) : {1'b0, f29};

  assign rnd   = p + (64'd1 << 29);
  assign x_now = rnd[59:30];
  assign hi    = p[61:30];
  assign v_now = OneQ30 - qk;
  assign c_now = 31'(OneQ30) - 31'(hi >> 1);

  always_comb begin
    case (ts)
      TS_S2_MUL, TS_C2_MUL: qk = 32'(p >> 38);
      TS_S3_MUL, TS_C3_MUL: qk = 32'(p >> 37);
      TS_S4_MUL, TS_C4_MUL: qk = 32'(p >> 36);
      TS_C5_MUL:            qk = 32'(p >> 35);
      TS_S_FINAL:           qk = 32'(p >> 34);
      default:              qk = '0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ts)
      TS_ANGLE:  begin mul_a = 32'(f_fold); mul_b = PiQ29;         end
      TS_SQUARE: begin mul_a = 32'(x_now);  mul_b = 32'(x_now);    end
      TS_S1_MUL, TS_C1_MUL: begin
        mul_a = hi;
        mul_b = OneQ30;
      end
      TS_S1_DIV: begin mul_a = hi; mul_b = RecipDiv72; end
      TS_S2_DIV: begin mul_a = hi; mul_b = RecipDiv42; end
      TS_S3_DIV: begin mul_a = hi; mul_b = RecipDiv20; end
      TS_S4_DIV: begin mul_a = hi; mul_b = RecipDiv6;  end
      TS_C1_DIV: begin mul_a = hi; mul_b = RecipDiv90; end
      TS_C2_DIV: begin mul_a = hi; mul_b = RecipDiv56; end
      TS_C3_DIV: begin mul_a = hi; mul_b = RecipDiv30; end
      TS_C4_DIV: begin mul_a = hi; mul_b = RecipDiv12; end
      TS_S2_MUL, TS_S3_MUL, TS_S4_MUL,
      TS_C2_MUL, TS_C3_MUL, TS_C4_MUL, TS_C5_MUL: begin
        mul_a = 32'(x2);
        mul_b = v_now;
      end
      TS_S_FINAL: begin mul_a = 32'(x); mul_b = v_now; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    // first cosine Horner step reads x squared from the x2 register, not the product
    if (ts == TS_C1_MUL) begin
      mul_a = 32'(x2);
    end
  end

  // octant mapping of sine and cosine
  assign qs     = trig_round(s_mag);
  assign qc     = trig_round(c_mag);
  assign swap   = oct[0] ^ oct[1];
  assign sn_neg = oct[2];
  assign cs_neg = oct[1] ^ oct[2];
  assign sin_v  = trig_sign(swap ? qc : qs, sn_neg);
  assign cos_v  = trig_sign(swap ? qs : qc, cs_neg);

  always_comb begin
    case (ps)
      PS_X1:   begin pl = $signed({1'b0, len_first});  pt = cos1;  end
      PS_X2:   begin pl = $signed({1'b0, len_second}); pt = cos12; end
      PS_Y1:   begin pl = $signed({1'b0, len_first});  pt = sin1;  end
      PS_Y2:   begin pl = $signed({1'b0, len_second}); pt = sin12; end
      default: begin pl = '0; pt = '0; end
    endcase
  end

  assign psum   = SumBits'(acc) + SumBits'(pm);
  assign pround = len_round(psum);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (job_avail) begin
        state_next = job.compute ? BK_TRIG : BK_EMIT;
      end
      BK_TRIG: if (ts == TS_QUANT && phase) begin
        state_next = BK_POS;
      end
      BK_POS: if (ps == PS_Y_DONE) begin
        state_next = BK_EMIT;
      end
      BK_EMIT: if (!out_valid || out_ready) begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // state outputs
  always_comb begin
    job_pop  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: job_pop  = job_avail;
      BK_TRIG: job_pop  = 1'b0;
      BK_POS:  job_pop  = 1'b0;
      BK_EMIT: load_out = !out_valid || out_ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (job_pop) begin
      cur   <= job;
      ts    <= TS_ANGLE;
      ps    <= PS_X1;
      phase <= 1'b0;
      res_x <= '0;
      res_y <= '0;
    end
    if (state == BK_TRIG) begin
      ts <= (ts == TS_QUANT) ? TS_ANGLE : trig_step_t'(ts + 5'd1);
      case (ts)
        TS_SQUARE:  x     <= x_now;
        TS_S1_MUL:  x2    <= hi[29:0];
        TS_C1_MUL:  s_mag <= hi[30:0];
        TS_C_DONE:  c_mag <= c_now;
        TS_QUANT: begin
          phase <= 1'b1;
          if (phase) begin
            sin12 <= sin_v;
            cos12 <= cos_v;
          end else begin
            sin1 <= sin_v;
            cos1 <= cos_v;
          end
        end
        default: ;
      endcase
    end
    if (state == BK_POS) begin
      ps <= pos_step_t'(ps + 3'd1);
      pm <= pl * pt;
      case (ps)
        PS_X2:     acc   <= pm;
        PS_Y1:     res_x <= pround;
        PS_Y2:     acc   <= pm;
        PS_Y_DONE: res_y <= pround;
        default: ;
      endcase
    end
    if (load_out) begin
      status          <= cur.status;
      pos_x           <= res_x;
      pos_y           <= res_y;
      bias_degrees    <= cur.deg;
      bias_first_now  <= cur.bias1;
      bias_second_now <= cur.bias2;
    end
  end

endmodule
`default_nettype wire

### design/two_link_arm_position_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_arm_position_core
// Forward kinematics of a two-link planar arm with joint bias calibration.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------
//  config   | psel/penable/pwrite, pready | paddr, pwdata, prdata
//  command  | in_valid / in_ready         | cmd, angle_first, angle_second,
//           |                             | read_failed
//  result   | out_valid / out_ready       | status, pos_x, pos_y, bias_degrees,
//           |                             | bias_first_now, bias_second_now
//
// A position command runs through the back end in order: fetch of the job,
// the sine and cosine series for each angle on the shared 32x32 multiplier,
// the link sums, and a load of the output register. Other commands go from
// the fetch straight to the output load. A two-entry job queue lets commands
// be taken while the back end is busy or the result waits. Reset clears the
// biases, disables the block and sets both link lengths to 1.
module two_link_arm_position_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlap_pkg::CfgAddrBits-1:0] paddr,
  input  logic [tlap_pkg::CfgDataBits-1:0] pwdata,
  output logic [tlap_pkg::CfgDataBits-1:0] prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [tlap_pkg::AngleBits-1:0]   angle_first,
  input  logic [tlap_pkg::AngleBits-1:0]   angle_second,
  input  logic                             read_failed,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic signed [tlap_pkg::PosBits-1:0] pos_x,
  output logic signed [tlap_pkg::PosBits-1:0] pos_y,
  output logic [tlap_pkg::DegBits-1:0]     bias_degrees,
  output logic [tlap_pkg::BiasOutBits-1:0] bias_first_now,
  output logic [tlap_pkg::BiasOutBits-1:0] bias_second_now
);
  import tlap_pkg::*;

  logic                  enabled;
  logic [LengthBits-1:0] len_first;
  logic [LengthBits-1:0] len_second;
  logic [LengthBits-1:0] wr_len;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  logic q_full;
  logic q_avail;
  logic push;
  logic pop;
  job_t job_in;
  job_t job_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_len  = pwdata[LengthBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      len_first  <= LengthBits'(1);
      len_second <= LengthBits'(1);
    end else if (cfg_wr) begin
      // drop zero lengths
      unique case (cfg_idx)
        REG_ENABLED: enabled <= pwdata[0];
        REG_LEN1:    if (wr_len != '0) len_first <= wr_len;
        REG_LEN2:    if (wr_len != '0) len_second <= wr_len;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLED: prdata = CfgDataBits'(enabled);
      REG_LEN1:    prdata = CfgDataBits'(len_first);
      REG_LEN2:    prdata = CfgDataBits'(len_second);
      default:     prdata = '0;
    endcase
  end

  tlap_front u_front (
    .clk          (clk),
    .rst          (rst),
    .enabled      (enabled),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .angle_first  (angle_first),
    .angle_second (angle_second),
    .read_failed  (read_failed),
    .q_full       (q_full),
    .push         (push),
    .job          (job_in)
  );

  tlap_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .pop   (pop),
    .dout  (job_out),
    .full  (q_full),
    .avail (q_avail)
  );

  tlap_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job             (job_out),
    .job_avail       (q_avail),
    .job_pop         (pop),
    .len_first       (len_first),
    .len_second      (len_second),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .bias_degrees    (bias_degrees),
    .bias_first_now  (bias_first_now),
    .bias_second_now (bias_second_now)
  );

  // a failed or rejected command carries no position
  a_err_no_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> pos_x == '0 && pos_y == '0)
    else $error("position on failed transfer");

  a_err_no_deg: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> bias_degrees == '0)
    else $error("degrees on failed transfer");

  a_load_no_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && bias_degrees != '0 |-> pos_x == '0 && pos_y == '0)
    else $error("position on bias load");

endmodule
`default_nettype wire

### dv/two_link_arm_position_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_arm_position_core_test
// Feeds arm commands with random gaps and back-pressure, predicts each result
// with an independent fixed-point kinematics model and compares field by field.
// ----------------------------------------------------------------------------
module two_link_arm_position_core_test;
  import tlap_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] a1;
    logic [15:0] a2;
    logic        fail;
  } arm_cmd_t;

  typedef struct packed {
    logic [1:0]         st;
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [15:0]        deg;
    logic [15:0]        b1;
    logic [15:0]        b2;
  } arm_res_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [CfgDataBits-1:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, read_failed, out_valid, out_ready;
  logic [1:0] cmd, status;
  logic [15:0] angle_first, angle_second, bias_degrees, bias_first_now, bias_second_now;
  logic signed [17:0] pos_x, pos_y;

  two_link_arm_position_core u_dut (.*);

  arm_cmd_t pending_cmds[$];
  arm_res_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int long_hold = 0;

  // predictor state
  logic        en_model;
  logic [15:0] len1_model, len2_model, bias1_model, bias2_model;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mq(logic [63:0] a, logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic int trig_q(logic [63:0] mag, bit neg);
    logic [63:0] q;
    q = (mag + (64'd1 << 14)) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return neg ? -int'(q) : int'(q);
  endfunction

  task automatic angle_trig(input logic [15:0] ang, output int sn, output int cs);
    logic [31:0] t, f;
    logic [2:0] oct;
    logic [63:0] x, x2, s, c;
    int qs, qc, ns, nc;
    t = {ang, 16'h0};
    oct = t[31:29];
    f = t & 32'h1FFF_FFFF;
    if (oct[0]) f = 32'h2000_0000 - f;
    x = (64'(f) * 64'd1686629713 + (64'd1 << 29)) >> 30;
    x2 = mq(x, x);
    s = (64'd1 << 30) - mq(x2, 64'd1 << 30) / 72;
    s = (64'd1 << 30) - mq(x2, s) / 42;
    s = (64'd1 << 30) - mq(x2, s) / 20;
    s = (64'd1 << 30) - mq(x2, s) / 6;
    s = mq(x, s);
    c = (64'd1 << 30) - mq(x2, 64'd1 << 30) / 90;
    c = (64'd1 << 30) - mq(x2, c) / 56;
    c = (64'd1 << 30) - mq(x2, c) / 30;
    c = (64'd1 << 30) - mq(x2, c) / 12;
    c = (64'd1 << 30) - mq(x2, c) / 2;
    // octants 1,2,5,6 swap the series; sign from the quadrant
    ns = oct[2];
    nc = (oct == 3'd2 || oct == 3'd3 || oct == 3'd4 || oct == 3'd5);
    if (oct == 3'd1 || oct == 3'd2 || oct == 3'd5 || oct == 3'd6) begin
      qs = trig_q(c, ns); qc = trig_q(s, nc);
    end else begin
      qs = trig_q(s, ns); qc = trig_q(c, nc);
    end
    sn = qs; cs = qc;
  endtask

  function automatic logic signed [17:0] round_len(longint p);
    longint q, r;
    q = p + (64'sd1 << 14);
    if (q >= 0) r = q >>> 15;
    else r = -((-q + 32767) >>> 15);
    if (r > 131071) r = 131071;
    if (r < -131071) r = -131071;
    return r[17:0];
  endfunction

  task automatic predict_arm(input arm_cmd_t c);
    arm_res_t r;
    logic [15:0] t1, t12;
    int s1, c1, s12, c12;
    r = '0;
    if (!en_model) begin
      r.st = ST_NOT_EN;
    end else if (c.fail && (c.op == CMD_POS || c.op == CMD_LOAD)) begin
      r.st = ST_READ_FAIL;
    end else if (c.op == CMD_POS) begin
      t1 = c.a1 - bias1_model;
      t12 = t1 + 16'(c.a2 - bias2_model);
      angle_trig(t1, s1, c1);
      angle_trig(t12, s12, c12);
      r.px = round_len(longint'(len1_model) * c1 + longint'(len2_model) * c12);
      r.py = round_len(longint'(len1_model) * s1 + longint'(len2_model) * s12);
    end else if (c.op == CMD_LOAD) begin
      bias1_model = c.a1;
      bias2_model = c.a2;
      r.deg = 16'((64'(c.a2) * 46080 + 64'd32768) >> 16);
    end else if (c.op == CMD_CLEAR) begin
      bias1_model = '0;
      bias2_model = '0;
    end
    r.b1 = bias1_model;
    r.b2 = bias2_model;
    expected_results.push_back(r);
  endtask

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver: offers queued commands, transfer on in_valid && in_ready
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      arm_cmd_t c;
      c = pending_cmds.pop_front();
      cmd <= c.op;
      angle_first <= c.a1;
      angle_second <= c.a2;
      read_failed <= c.fail;
      in_valid <= 1'b1;
      in_gap <= gap_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      predict_arm('{cmd, angle_first, angle_second, read_failed});
      sent++;
    end
  end

  // receiver stall pattern
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_gap <= gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      arm_res_t e;
      received++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.st || pos_x !== e.px || pos_y !== e.py
            || bias_degrees !== e.deg || bias_first_now !== e.b1
            || bias_second_now !== e.b2) begin
          $display("%0t: mismatch exp st=%0d x=%0d y=%0d deg=%0d b=%h/%h",
                   $time, e.st, e.px, e.py, e.deg, e.b1, e.b2);
          $display("%0t:          got st=%0d x=%0d y=%0d deg=%0d b=%h/%h",
                   $time, status, pos_x, pos_y, bias_degrees, bias_first_now,
                   bias_second_now);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CfgAddrBits'(4 * idx); pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ENABLED: en_model = v[0];
      REG_LEN1: if (v[15:0] != 0) len1_model = v[15:0];
      REG_LEN2: if (v[15:0] != 0) len2_model = v[15:0];
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input cmd_t op, input logic [15:0] a1, input logic [15:0] a2,
                           input logic f);
    pending_cmds.push_back('{op, a1, a2, f});
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'(($urandom_range(0, 7)) << 13);
      1: return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 2) - 1);
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n);
    cmd_t op;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: op = CMD_LOAD;
        2: op = CMD_CLEAR;
        3: op = CMD_NOP;
        default: op = CMD_POS;
      endcase
      queue_cmd(op, pick_angle(), pick_angle(), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; out_ready = 0; cmd = '0;
    angle_first = '0; angle_second = '0; read_failed = 0;
    en_model = 0; len1_model = 1; len2_model = 1; bias1_model = 0; bias2_model = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // disabled: everything rejected
    queue_cmd(CMD_POS, 16'h1234, 16'h4321, 0);
    queue_cmd(CMD_LOAD, 16'h1111, 16'h2222, 1);
    queue_cmd(CMD_CLEAR, 0, 0, 0);
    drain();

    reg_write(REG_LEN1, 32'd0);
    reg_write(REG_LEN2, 32'd0);
    reg_write(REG_ENABLED, 32'd1);
    queue_cmd(CMD_POS, 16'h0000, 16'h0000, 0);
    drain();
    reg_write(REG_LEN1, 32'd65535);
    reg_write(REG_LEN2, 32'd65535);
    drain();
    // directed extremes, octant edges, failures, unused command
    queue_cmd(CMD_POS, 16'h0000, 16'h0000, 0);
    queue_cmd(CMD_POS, 16'hFFFF, 16'hFFFF, 0);
    queue_cmd(CMD_POS, 16'h2000, 16'h6000, 0);
    queue_cmd(CMD_POS, 16'h4000, 16'h8000, 0);
    queue_cmd(CMD_POS, 16'hA000, 16'hE000, 0);
    queue_cmd(CMD_POS, 16'h1FFF, 16'h2001, 0);
    queue_cmd(CMD_POS, 16'h5555, 16'hAAAA, 1);
    queue_cmd(CMD_LOAD, 16'hFFFF, 16'hFFFF, 0);
    queue_cmd(CMD_POS, 16'h0000, 16'h0000, 0);
    queue_cmd(CMD_LOAD, 16'h0123, 16'h8000, 1);
    queue_cmd(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1);
    queue_cmd(CMD_NOP, 16'hFFFF, 16'h0000, 1);
    queue_cmd(CMD_LOAD, 16'h0000, 16'h0001, 0);
    drain();

    reg_write(REG_LEN1, 32'd1);
    reg_write(REG_LEN2, 32'd1);
    random_phase(300);
    drain();
    reg_write(REG_LEN1, 32'd40000);
    reg_write(REG_LEN2, 32'd777);
    random_phase(300);
    // hold the receiver while commands pile up
    long_hold = 400;
    drain();
    reg_write(REG_ENABLED, 32'd0);
    random_phase(100);
    drain();
    reg_write(REG_ENABLED, 32'd1);
    for (int p = 0; p < 3; p++) begin
      reg_write(REG_LEN1, 32'($urandom_range(1, 65535)));
      reg_write(REG_LEN2, 32'($urandom_range(1, 65535)));
      random_phase(300);
      drain();
    end

    $display("Sent %0d commands, checked %0d results over link, enable and bias settings",
             sent, received);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout after %0d results", received);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
